// ===== hw/rtl/ebs_pkg.sv =====
// ebs_pkg: constants, types and state codes for the beat superposition core.
// No dependencies; imported by ebs_acc and ecg_beat_superposition_core.
`timescale 1ns / 1ps
package ebs_pkg;
	localparam int NUM_LEADS   = 12;
	localparam int NUM_RHYTHMS = 4;
	localparam int MAX_SAMPLES = 1024;
	localparam int MAX_ACTIVE  = 4;
	localparam int TEMPLATES   = NUM_LEADS * NUM_RHYTHMS;
	localparam int PTRS        = TEMPLATES * MAX_ACTIVE;
	localparam int LW = 4;
	localparam int RW = 2;
	localparam int IW = 10;
	localparam int TW = $clog2(TEMPLATES);
	localparam int PW = $clog2(PTRS);
	localparam int SW = $clog2(TEMPLATES * MAX_SAMPLES);
	localparam int LENW = IW + 1;
	localparam int AW = $clog2(MAX_ACTIVE) > 0 ? $clog2(MAX_ACTIVE) : 1;
	localparam int ACCW = 24;

	localparam logic [1:0] ACT_LOAD  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_NOSLOT  = 2'd2;
	localparam logic [1:0] REG_LEAD_ENABLE = 2'd0;

	typedef enum logic [3:0] {
		S_IDLE, S_CHECK, S_OPEN, S_STAT, S_PTR, S_RD, S_ACC, S_EMIT, S_HOLD
	} state_t;

	// store write request from a load command
	typedef struct packed {
		logic          we;
		logic [SW-1:0] waddr;
		logic [15:0]   wdata;
	} ram_wr_t;
endpackage

// ===== hw/rtl/ebs_ram.sv =====
// ebs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module ebs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/ebs_acc.sv =====
// ebs_acc: shared saturating accumulator for one lead sum.
// Depends on ebs_pkg.
`timescale 1ns / 1ps
module ebs_acc (
	input  logic                       clk,
	input  logic                       clr,
	input  logic                       add,
	input  logic signed [15:0]         sample,
	output logic signed [ebs_pkg::ACCW-1:0] sum
);
	import ebs_pkg::*;
	// 16 terms of 16 bits per lead fit comfortably in 32 bits; clamp on output
	logic signed [31:0] acc_q;
	always_ff @(posedge clk) begin
		if (clr) acc_q <= '0;
		else if (add) acc_q <= acc_q + 32'(sample);
	end
	always_comb begin
		if (acc_q > 32'sd8388607) sum = 24'sh7FFFFF;
		else if (acc_q < -32'sd8388608) sum = 24'sh800000;
		else sum = acc_q[ACCW-1:0];
	end
endmodule

// ===== hw/rtl/ecg_beat_superposition_core.sv =====
// ecg_beat_superposition_core: top level of the ECG beat superposition block.
// Depends on ebs_pkg, ebs_ram and ebs_acc.
`timescale 1ns / 1ps
// Usage:
//  s_axis: one transfer per command. tuser = action; tlast = final_sample;
//   tdata = {lead, rhythm, sample_index, sample_value} from bit 0 up, 32 bits.
//  m_axis: results. tdata = {out_lead, potential, status} from bit 0 up;
//   tuser = kind; tlast marks the final result of a command.
//  APB: register 0 (addr 0) is lead_enable, 12 bits; the user writes it only
//   while idle, as the block leaves this rule unchecked. Load: no result;
//   ready stays high. Start: two check passes over the leads, then an open
//   pass; when rejected, no pointer is opened; one status result. Tick: per
//   enabled lead the walk visits each of the 16 pointer slots, reads position
//   and then sample for each live pointer, and emits one lead result; a
//   disabled lead is skipped; a closing state ends the walk. The single sample
//   store read port and the shared accumulator make the walk serial.
//  The block takes one command at a time; s_axis_tready is low while it works.
//  When the receiver stalls, the result is held in the output register and
//  the sequencer waits. Reset clears template flags and pointer valid bits at
//  once; the sample store, template lengths and pointer positions are not
//  cleared, as each is read only after it has been written.
module ecg_beat_superposition_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // lead, rhythm, sample_index, sample_value
	input  logic [1:0]  s_axis_tuser,   // action
	input  logic        s_axis_tlast,   // final_sample
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // out_lead, potential, status
	output logic        m_axis_tuser,   // kind
	output logic        m_axis_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ebs_pkg::*;

	state_t state_q, state_d;
	logic [11:0] en_q;
	logic [TEMPLATES-1:0] pres_q;
	logic [PTRS-1:0] act_q;
	// walk counters
	logic [LW-1:0] ld_q;
	logic [RW-1:0] r_q;
	logic [AW-1:0] s_q;
	logic [1:0] stat_q;
	logic [1:0] mode_q;   // 0 check missing, 1 check slot
	// output register
	logic        ov_q;
	logic [3:0]  ol_q;
	logic signed [23:0] op_q;
	logic [1:0]  os_q;
	logic        ok_q, olast_q;

	assign pready = 1'b1;
	assign prdata = {20'd0, en_q};
	assign s_axis_tready = (state_q == S_IDLE);
	wire s_acc = s_axis_tvalid && s_axis_tready;

	wire [1:0]  in_act = s_axis_tuser;
	wire [3:0]  in_ld  = s_axis_tdata[3:0];
	wire [1:0]  in_rh  = s_axis_tdata[5:4];
	wire [9:0]  in_idx = s_axis_tdata[15:6];
	wire [15:0] in_val = s_axis_tdata[31:16];
	wire        in_fin = s_axis_tlast;

	// current template and pointer indices
	wire [TW-1:0] tmpl_w = TW'(ld_q * NUM_RHYTHMS + r_q);
	wire [PW-1:0] ptr_w  = PW'(tmpl_w * MAX_ACTIVE + s_q);
	wire lead_on = (ld_q < LW'(NUM_LEADS)) && en_q[ld_q];
	wire last_lead = (ld_q == LW'(NUM_LEADS - 1));

	// free slot scan for template tmpl_w (combinational over MAX_ACTIVE bits)
	logic free_found;
	logic [AW-1:0] free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot = '0;
		for (int i = MAX_ACTIVE - 1; i >= 0; i--) begin
			if (!act_q[PW'(tmpl_w * MAX_ACTIVE + i)]) begin
				free_found = 1'b1;
				free_slot = AW'(i);
			end
		end
	end

	ram_wr_t wr;
	logic [SW-1:0] raddr;
	logic signed [15:0] rdata;
	logic [IW-1:0] pos_rd;
	logic [LENW-1:0] len_rd;
	assign wr.we = s_acc && in_act == ACT_LOAD && in_ld < LW'(NUM_LEADS);
	assign wr.waddr = SW'((in_ld * NUM_RHYTHMS + in_rh) * MAX_SAMPLES + in_idx);
	assign wr.wdata = in_val;
	// pointer position arrives in the cycle after the slot is visited
	assign raddr = SW'(tmpl_w * MAX_SAMPLES + pos_rd);

	ebs_ram #(.WIDTH(16), .DEPTH(TEMPLATES * MAX_SAMPLES)) u_store (
		.clk(clk), .we(wr.we), .waddr(wr.waddr), .wdata(wr.wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// template lengths, written by a final sample, read during the tick walk
	wire            len_we    = wr.we && in_fin;
	wire [TW-1:0]   len_waddr = TW'(in_ld * NUM_RHYTHMS + in_rh);
	wire [LENW-1:0] len_wdata = LENW'(in_idx) + LENW'(1);
	ebs_ram #(.WIDTH(LENW), .DEPTH(TEMPLATES)) u_len (
		.clk(clk), .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(tmpl_w), .rdata(len_rd)
	);

	// pointer positions: cleared on open, advanced after each read unless the pointer retires
	wire retire = (LENW'(pos_rd) + LENW'(1)) >= len_rd;
	logic pos_we;
	logic [PW-1:0] pos_waddr;
	logic [IW-1:0] pos_wdata;
	always_comb begin
		pos_we = 1'b0;
		pos_waddr = ptr_w;
		pos_wdata = pos_rd + IW'(1);
		if (state_q == S_OPEN) begin
			pos_we = lead_on && stat_q == ST_OK;
			pos_waddr = PW'(tmpl_w * MAX_ACTIVE + free_slot);
			pos_wdata = '0;
		end else if (state_q == S_ACC) begin
			pos_we = !retire;
		end
	end
	ebs_ram #(.WIDTH(IW), .DEPTH(PTRS)) u_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.raddr(ptr_w), .rdata(pos_rd)
	);

	logic acc_clr, acc_add;
	logic signed [23:0] acc_sum;
	ebs_acc u_acc (.clk(clk), .clr(acc_clr), .add(acc_add), .sample(rdata), .sum(acc_sum));

	wire out_free = !ov_q || m_axis_tready;
	wire out_load = out_free && (state_q == S_STAT || state_q == S_EMIT);
	wire last_slot = (r_q == RW'(NUM_RHYTHMS - 1)) && (s_q == AW'(MAX_ACTIVE - 1));

	// next-state logic
	always_comb begin
		state_d = state_q;
		acc_clr = 1'b0;
		acc_add = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				acc_clr = 1'b1;
				if (s_acc) begin
					if (in_act == ACT_START) state_d = S_CHECK;
					else if (in_act == ACT_TICK) state_d = S_PTR;
				end
			end
			S_CHECK: if (last_lead && mode_q == 2'd1) state_d = S_OPEN;
			S_OPEN:  if (last_lead || stat_q != ST_OK) state_d = S_STAT;
			S_STAT:  if (out_free) state_d = S_IDLE;
			S_PTR: begin
				if (!lead_on) begin
					if (last_lead) state_d = S_HOLD;
				end else if (act_q[ptr_w]) state_d = S_RD;
				else if (last_slot) state_d = S_EMIT;
			end
			S_RD: state_d = S_ACC;
			S_ACC: begin
				acc_add = 1'b1;
				state_d = last_slot ? S_EMIT : S_PTR;
			end
			S_EMIT: if (out_free) begin
				acc_clr = 1'b1;
				state_d = last_lead ? S_HOLD : S_PTR;
			end
			S_HOLD: if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

	// is any later enabled lead? used to set tlast on a lead result
	logic more_leads;
	always_comb begin
		more_leads = 1'b0;
		for (int i = 0; i < NUM_LEADS; i++)
			if (LW'(i) > ld_q && en_q[i]) more_leads = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= '0; pres_q <= '0; act_q <= '0; ov_q <= 1'b0;
			ld_q <= '0; r_q <= '0; s_q <= '0; stat_q <= ST_OK; mode_q <= '0;
			ok_q <= 1'b0; ol_q <= '0; op_q <= '0; os_q <= ST_OK; olast_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite && paddr == REG_LEAD_ENABLE) en_q <= pwdata[11:0];
			ov_q <= out_load || (ov_q && !m_axis_tready);
			if (len_we) pres_q[len_waddr] <= 1'b1;
			unique case (state_q)
				S_IDLE: if (s_acc) begin
					ld_q <= '0; s_q <= '0;
					r_q <= (in_act == ACT_START) ? in_rh : '0;
					stat_q <= ST_OK; mode_q <= '0;
				end
				S_CHECK: begin
					if (lead_on && stat_q == ST_OK) begin
						if (mode_q == 2'd0 && !pres_q[tmpl_w]) stat_q <= ST_MISSING;
						if (mode_q == 2'd1 && !free_found) stat_q <= ST_NOSLOT;
					end
					if (last_lead) begin
						ld_q <= '0;
						mode_q <= mode_q + 2'd1;
					end else ld_q <= ld_q + LW'(1);
				end
				S_OPEN: begin
					if (lead_on && stat_q == ST_OK)
						act_q[PW'(tmpl_w * MAX_ACTIVE + free_slot)] <= 1'b1;
					ld_q <= ld_q + LW'(1);
				end
				S_STAT: if (out_free) begin
					ok_q <= 1'b1; ol_q <= '0; op_q <= '0;
					os_q <= stat_q; olast_q <= 1'b1;
				end
				S_PTR: begin
					if (!lead_on) begin
						ld_q <= ld_q + LW'(1);
					end else if (!act_q[ptr_w] && !last_slot) begin
						{r_q, s_q} <= {r_q, s_q} + (RW + AW)'(1);
					end
				end
				S_ACC: begin
					if (retire) act_q[ptr_w] <= 1'b0;
					if (!last_slot) {r_q, s_q} <= {r_q, s_q} + (RW + AW)'(1);
				end
				S_EMIT: if (out_free) begin
					ok_q <= 1'b0; ol_q <= ld_q; op_q <= acc_sum;
					os_q <= ST_OK; olast_q <= !more_leads;
					ld_q <= ld_q + LW'(1); r_q <= '0; s_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = {2'b00, os_q, op_q, ol_q};
	assign m_axis_tuser = ok_q;
	assign m_axis_tlast = olast_q;

`ifndef NO_ASSERTIONS
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_ok_out: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |-> os_q == ST_OK) else $error("status on potential");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(op_q)) else $error("output changed");
`endif
endmodule
